// ===== hdl/lpnal2sc_pkg.sv =====
package lpnal2sc_pkg;

  // widths fixed by the stream format
  localparam int BYTE_W = 8;
  localparam int CFG_W = 3;
  localparam int SEEN_W = 2;
  localparam int START_CODE_LEN = 4;
  localparam int SC_IDX_W = 2;

  // defaults for the top-level parameters
  localparam int LEN_BYTES_DEFAULT = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 3'd4;

  localparam logic [BYTE_W-1:0] START_CODE [START_CODE_LEN] =
    '{8'h00, 8'h00, 8'h00, 8'h01};

  // work item handed from the front to the back
  typedef enum logic [2:0] {
    CMD_PASS  = 3'b001,
    CMD_START = 3'b010,
    CMD_MARK  = 3'b100
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } cmd_t;

endpackage

// ===== hdl/lpnal2sc_front.sv =====
module lpnal2sc_front #(
  parameter int MAX_LENGTH_BYTES = lpnal2sc_pkg::LEN_BYTES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lpnal2sc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                              packet_end,
  input  logic                              accept,
  input  logic                              cfg_we,
  input  logic [lpnal2sc_pkg::CFG_W-1:0]    cfg_data,
  output lpnal2sc_pkg::cmd_t                cmd,
  output logic                              cmd_valid
);
  import lpnal2sc_pkg::*;

  localparam int ACC_W = BYTE_W * MAX_LENGTH_BYTES;

  logic [CFG_W-1:0]  field_size;
  logic              in_payload, in_payload_next;
  logic [SEEN_W-1:0] len_seen, len_seen_next;
  logic [ACC_W-1:0]  len_acc, len_acc_next;
  logic [ACC_W-1:0]  remaining, remaining_next;

  logic [CFG_W-1:0]        eff_size;
  logic [CFG_W-1:0]        seen;
  logic [ACC_W+BYTE_W-1:0] acc_wide;
  logic [ACC_W-1:0]        acc_shift;

  always_comb begin
    if (field_size == '0) begin
      eff_size = CFG_W'(1);
    end else if (field_size > CFG_W'(MAX_LENGTH_BYTES)) begin
      eff_size = CFG_W'(MAX_LENGTH_BYTES);
    end else begin
      eff_size = field_size;
    end
  end

  assign seen      = CFG_W'(len_seen) + CFG_W'(1);
  assign acc_wide  = {len_acc, data_byte};
  assign acc_shift = acc_wide[ACC_W-1:0];

  always_comb begin
    cmd.kind        = CMD_PASS;
    cmd.data        = data_byte;
    cmd.last        = packet_end;
    cmd_valid       = 1'b1;
    in_payload_next = in_payload;
    len_seen_next   = len_seen;
    len_acc_next    = len_acc;
    remaining_next  = remaining;
    if (in_payload) begin
      remaining_next = remaining - ACC_W'(1);
      if (remaining == ACC_W'(1)) begin
        in_payload_next = 1'b0;
      end
    end else begin
      len_acc_next = acc_shift;
      if (seen >= eff_size) begin
        len_seen_next = '0;
        len_acc_next  = '0;
        if (packet_end) begin
          cmd.kind = CMD_MARK;
        end else begin
          cmd.kind        = CMD_START;
          remaining_next  = acc_shift;
          in_payload_next = (acc_shift != '0);
        end
      end else begin
        len_seen_next = seen[SEEN_W-1:0];
        // length field bytes are swallowed unless the packet ends here
        cmd_valid     = packet_end;
        if (packet_end) begin
          cmd.kind = CMD_MARK;
        end
      end
    end
    // end of access unit: back to expecting a length field
    if (packet_end) begin
      in_payload_next = 1'b0;
      len_seen_next   = '0;
      len_acc_next    = '0;
      remaining_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_size <= CFG_SIZE_RESET;
      in_payload <= 1'b0;
      len_seen   <= '0;
      len_acc    <= '0;
      remaining  <= '0;
    end else begin
      if (cfg_we) begin
        field_size <= cfg_data;
      end
      if (accept) begin
        in_payload <= in_payload_next;
        len_seen   <= len_seen_next;
        len_acc    <= len_acc_next;
        remaining  <= remaining_next;
      end
    end
  end

endmodule

// ===== hdl/lpnal2sc_queue.sv =====
module lpnal2sc_queue #(
  parameter int DEPTH = lpnal2sc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  lpnal2sc_pkg::cmd_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output lpnal2sc_pkg::cmd_t rd_data,
  output logic               empty
);
  import lpnal2sc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lpnal2sc_back.sv =====
module lpnal2sc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  lpnal2sc_pkg::cmd_t              head,
  input  logic                            head_empty,
  output logic                            head_pop,
  output logic [lpnal2sc_pkg::BYTE_W-1:0] out_byte,
  output logic                            byte_valid,
  output logic                            unit_start,
  output logic                            packet_done,
  output logic                            run_last,
  output logic                            empty,
  input  logic                            pop
);
  import lpnal2sc_pkg::*;

  logic                out_full;
  logic [SC_IDX_W-1:0] sc_idx;
  logic                load;

  logic [BYTE_W-1:0] byte_next;
  logic              valid_next, start_next, done_next, last_next;
  logic              item_done;

  assign load     = (!out_full || pop) && !head_empty;
  assign head_pop = load && item_done;
  assign empty    = !out_full;

  always_comb begin
    byte_next  = head.data;
    valid_next = 1'b1;
    start_next = 1'b0;
    done_next  = head.last;
    last_next  = 1'b1;
    item_done  = 1'b1;
    case (head.kind)
      CMD_PASS: begin
      end
      CMD_START: begin
        byte_next  = START_CODE[sc_idx];
        start_next = (sc_idx == '0);
        done_next  = 1'b0;
        last_next  = (sc_idx == SC_IDX_W'(START_CODE_LEN - 1));
        item_done  = last_next;
      end
      CMD_MARK: begin
        byte_next  = '0;
        valid_next = 1'b0;
        done_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      sc_idx   <= '0;
    end else begin
      if (load) begin
        out_full <= 1'b1;
        sc_idx   <= item_done ? '0 : sc_idx + SC_IDX_W'(1);
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= byte_next;
      byte_valid  <= valid_next;
      unit_start  <= start_next;
      packet_done <= done_next;
      run_last    <= last_next;
    end
  end

endmodule

// ===== hdl/length_prefixed_nal_to_start_codes_unit.sv =====
// an accepted byte's command is written into the command queue, then loaded into the result register
// throughput: one input byte per cycle while results drain; a completed length field
//   expands into four start-code results, one per cycle from the result register,
//   so input stalls once the queue fills; swallowed length bytes produce no result
// the command queue between front and back absorbs those bursts (QUEUE_DEPTH entries)
// reset (rst, synchronous): queue and result register empty, length field size 4,
//   parser expecting a length field
module length_prefixed_nal_to_start_codes_unit #(
  parameter int MAX_LENGTH_BYTES = lpnal2sc_pkg::LEN_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = lpnal2sc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input byte stream
  input  logic [lpnal2sc_pkg::BYTE_W-1:0] data_byte,
  input  logic                            packet_end,
  input  logic                            push,
  output logic                            full,
  // result stream
  output logic [lpnal2sc_pkg::BYTE_W-1:0] out_byte,
  output logic                            byte_valid,
  output logic                            unit_start,
  output logic                            packet_done,
  output logic                            run_last,
  output logic                            empty,
  input  logic                            pop,
  // length field size register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpnal2sc_pkg::CFG_W-1:0]  cfg_data
);
  import lpnal2sc_pkg::*;

  // front to queue
  cmd_t front_cmd;
  logic front_valid;
  logic accept;
  // queue to back
  cmd_t head;
  logic head_empty;
  logic head_pop;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // byte transfer happens whenever the queue has room
  assign accept = push && !full;

  // front: tracks length field / payload and turns each byte into at most one command
  lpnal2sc_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .packet_end(packet_end),
    .accept    (accept),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  // short command queue so the front keeps taking bytes during start-code bursts
  lpnal2sc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept && front_valid),
    .wr_data(front_cmd),
    .full   (full),
    .rd_en  (head_pop),
    .rd_data(head),
    .empty  (head_empty)
  );

  // back: expands commands into the result register, one result per cycle while results drain
  lpnal2sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .unit_start (unit_start),
    .packet_done(packet_done),
    .run_last   (run_last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== tb/length_prefixed_nal_to_start_codes_unit_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_nal_to_start_codes_unit_tb;
  import lpnal2sc_pkg::*;

  localparam int MAX_LEN_BYTES = LEN_BYTES_DEFAULT;
  // cycles to let the block finish internal work once nothing is expected
  // (the command queue and the result register draining)
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH_DEFAULT + 4;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_LIMIT = 5000;

  // one converted output record
  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              valid;
    logic              ustart;
    logic              done;
    logic              last;
  } annexb_rec_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              packet_end = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              unit_start;
  logic              packet_done;
  logic              run_last;
  logic              empty;
  logic              pop = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // our own copy of the converter state and the size register
  logic [CFG_W-1:0]  length_size = CFG_SIZE_RESET;
  logic              in_nal = 1'b0;
  logic [SEEN_W-1:0] len_seen = '0;
  logic [31:0]       len_acc = '0;
  logic [31:0]       nal_left = '0;

  // converted bytes still to come out of the block, oldest first
  annexb_rec_t annexb_due[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int send_gap_max = 5;
  int pop_stall_max = 5;

  length_prefixed_nal_to_start_codes_unit dut (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .packet_end  (packet_end),
    .push        (push),
    .full        (full),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .unit_start  (unit_start),
    .packet_done (packet_done),
    .run_last    (run_last),
    .empty       (empty),
    .pop         (pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size that the parser actually uses: 0 acts as 1, anything past the max is clamped
  function automatic int eff_size();
    int s;
    s = int'(length_size);
    if (s < 1) s = 1;
    if (s > MAX_LEN_BYTES) s = MAX_LEN_BYTES;
    return s;
  endfunction

  // convert one accepted input byte into the records it should produce
  task automatic convert_byte(input logic [BYTE_W-1:0] b, input logic eop);
    annexb_rec_t run [START_CODE_LEN];
    int n;
    int seen;
    n = 0;
    if (in_nal) begin
      // payload byte passes straight through
      run[n] = '{b, 1'b1, 1'b0, 1'b0, 1'b0};
      n++;
      nal_left = nal_left - 1;
      if (nal_left == 0) in_nal = 1'b0;
    end else begin
      // length field byte, big-endian, swallowed
      seen = int'(len_seen) + 1;
      len_acc = {len_acc[23:0], b};
      if (seen >= eff_size()) begin
        // field complete; no start code if the packet ends right here
        if (!eop) begin
          for (int i = 0; i < START_CODE_LEN; i++) begin
            run[n] = '{START_CODE[i], 1'b1, (i == 0), 1'b0, 1'b0};
            n++;
          end
          nal_left = len_acc;
          in_nal = (len_acc != 0);
        end
        len_seen = '0;
        len_acc = '0;
      end else begin
        len_seen = seen[SEEN_W-1:0];
      end
    end
    if (eop) begin
      // bare end marker when nothing else came out of this byte
      if (n == 0) begin
        run[n] = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
        n++;
      end
      run[n-1].done = 1'b1;
      in_nal = 1'b0;
      len_seen = '0;
      len_acc = '0;
      nal_left = '0;
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) annexb_due.push_back(run[i]);
  endtask

  // one input transfer, preceded by a random gap
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eop);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    packet_end <= eop;
    do @(posedge clk); while (full);
    convert_byte(b, eop);
    items_sent++;
  endtask

  // stop sending and wait until every expected record has come out
  task automatic settle();
    push <= 1'b0;
    while (annexb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever done on an idle block
  task automatic set_length_size(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_size = v;
  endtask

  // full 4-byte field with extreme byte values, one payload byte ending the packet
  task automatic test_start_code_insertion();
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b1);
  endtask

  // shrink the field size after two of four bytes: the third byte completes it
  task automatic test_resize_mid_field();
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    set_length_size(3'd2);
    push_byte(8'h01, 1'b0);
    push_byte(8'hC3, 1'b1);
  endtask

  // zero length: start code, then the next byte is a new length field
  task automatic test_zero_length();
    set_length_size(3'd1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
  endtask

  // packet ending inside a field, exactly on its last byte, and overrunning a unit
  task automatic test_packet_end_cases();
    set_length_size(3'd2);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'hAA, 1'b1);
  endtask

  // register values outside 1..4
  task automatic test_size_out_of_range();
    set_length_size(3'd0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    set_length_size(3'd7);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
  endtask

  // one access unit: mostly well formed, some with overrun lengths or cut short
  task automatic send_random_access_unit();
    int sz;
    int kind;
    int units;
    int len;
    int k;
    logic [31:0] lv;
    sz = eff_size();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      units = $urandom_range(1, 3);
      for (int u = 0; u < units; u++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
        // the last unit carries the packet end, so it needs a byte
        if (u == units - 1 && len == 0) len = 1;
        lv = len;
        for (int i = 0; i < sz; i++) push_byte(lv[8*(sz-1-i) +: 8], 1'b0);
        for (int j = 0; j < len; j++)
          push_byte(BYTE_W'($urandom_range(0, 255)), (u == units - 1 && j == len - 1));
      end
    end else if (kind == 7) begin
      // random, usually huge length that the packet end cuts off
      lv = $urandom;
      for (int i = 0; i < sz; i++) push_byte(lv[8*(sz-1-i) +: 8], 1'b0);
      k = $urandom_range(1, 6);
      for (int j = 0; j < k; j++) push_byte(BYTE_W'($urandom_range(0, 255)), (j == k - 1));
    end else if (kind == 8) begin
      // packet ends inside the length field or right where it completes
      k = $urandom_range(1, sz);
      for (int j = 0; j < k; j++) push_byte(BYTE_W'($urandom_range(0, 255)), (j == k - 1));
    end else begin
      k = $urandom_range(1, 8);
      for (int j = 0; j < k; j++) push_byte(BYTE_W'($urandom_range(0, 255)), (j == k - 1));
    end
  endtask

  // phases over register values, with and without idling on either side
  task automatic test_random_streams();
    logic [CFG_W-1:0] sizes [8];
    int phase;
    sizes = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_length_size(phase < 8 ? sizes[phase] : CFG_W'($urandom_range(0, 7)));
      case (phase % 4)
        1: begin
          send_gap_max = 0;
          pop_stall_max = 0;
        end
        3: begin
          send_gap_max = 0;
          pop_stall_max = 5;
        end
        default: begin
          send_gap_max = 5;
          pop_stall_max = 5;
        end
      endcase
      repeat (2) send_random_access_unit();
      phase++;
    end
    send_gap_max = 5;
    pop_stall_max = 5;
  endtask

  // result side: random stalls, each transfer checked against the oldest expectation
  initial begin : result_check
    annexb_rec_t want;
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, pop_stall_max);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (annexb_due.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_valid %0b", out_byte, byte_valid);
        mismatch_count++;
      end else begin
        want = annexb_due.pop_front();
        if (out_byte !== want.b) begin
          $error("out_byte: expected %0h, got %0h", want.b, out_byte);
          mismatch_count++;
        end
        if (byte_valid !== want.valid) begin
          $error("byte_valid: expected %0b, got %0b", want.valid, byte_valid);
          mismatch_count++;
        end
        if (unit_start !== want.ustart) begin
          $error("unit_start: expected %0b, got %0b", want.ustart, unit_start);
          mismatch_count++;
        end
        if (packet_done !== want.done) begin
          $error("packet_done: expected %0b, got %0b", want.done, packet_done);
          mismatch_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, run_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : main_sequence
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_start_code_insertion();
    test_resize_mid_field();
    test_zero_length();
    test_packet_end_cases();
    test_size_out_of_range();
    test_random_streams();
    // drain whatever is still in flight, bounded
    push <= 1'b0;
    waited = 0;
    while (annexb_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (annexb_due.size() != 0) begin
      $error("%0d expected results never came out", annexb_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lpnal2sc_pkg.sv
hdl/lpnal2sc_front.sv
hdl/lpnal2sc_queue.sv
hdl/lpnal2sc_back.sv
hdl/length_prefixed_nal_to_start_codes_unit.sv
tb/length_prefixed_nal_to_start_codes_unit_tb.sv
